// File: src/sprite_box_scale_clip_unit_assert.svh
// Assertion helpers for the sprite box scale and clip unit.
`ifndef SPRITE_BOX_SCALE_CLIP_UNIT_ASSERT_SVH
`define SPRITE_BOX_SCALE_CLIP_UNIT_ASSERT_SVH

// Generic clocked check with synchronous reset masking.
`define SBSC_CHECK(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Same-cycle implication on clk/rst.
`define SBSC_IMPLIES(label, ante, cons, msg) \
  `SBSC_CHECK(label, clk, rst, (ante) |-> (cons), msg)

`endif

// File: src/sbsc_pkg.sv
// ----------------------------------------------------------------------------
// sbsc_pkg
// Shared widths, register codes, constants and helpers of the sprite box unit.
// ----------------------------------------------------------------------------
package sbsc_pkg;

  localparam int FW    = 16;  // frame / alt box field
  localparam int SZW   = 12;  // size percent
  localparam int RW    = 24;  // result coordinate
  localparam int PW    = 10;  // play area register
  localparam int IDXW  = 2;   // config index
  localparam int SATW  = 40;  // saturation input width

  localparam logic [IDXW-1:0] REG_PLAY_RIGHT  = 2'd0;
  localparam logic [IDXW-1:0] REG_PLAY_LEFT   = 2'd1;
  localparam logic [IDXW-1:0] REG_PLAY_BOTTOM = 2'd2;

  localparam logic [PW-1:0] PLAY_RIGHT_RST  = 10'd620;
  localparam logic [PW-1:0] PLAY_LEFT_RST   = 10'd20;
  localparam logic [PW-1:0] PLAY_BOTTOM_RST = 10'd400;
  localparam logic [PW-1:0] SCREEN_W        = 10'd640;
  localparam logic [PW-1:0] SCREEN_H        = 10'd480;

  localparam int FLAG_NOCLIP = 0;
  localparam int FLAG_SKIP   = 1;
  localparam int FLAG_FRAME  = 2;

  localparam logic [SZW-1:0] SIZE_UNIT = 12'd100;

  // floor(2^32/d) reciprocals; quotient estimate is low by at most one
  localparam logic [25:0] M100 = 26'd42949672;
  localparam logic [24:0] M200 = 25'd21474836;
  localparam logic [27:0] D100 = 28'd100;
  localparam logic [27:0] D200 = 28'd200;

  localparam logic signed [SATW-1:0] SAT_MAX = 40'sd8388607;
  localparam logic signed [SATW-1:0] SAT_MIN = -40'sd8388608;

  typedef struct packed {
    logic            frame;
    logic            skip;
    logic [PW-1:0]   pl;
    logic [PW-1:0]   pr;
    logic [PW-1:0]   pb;
    logic [SZW-1:0]  sfix;
    logic [FW-1:0]   rl;
    logic [FW-1:0]   rt;
    logic [FW-1:0]   rr;
    logic [FW-1:0]   rb;
    logic [FW-1:0]   dl;
    logic [FW-1:0]   dt;
    logic [FW-1:0]   dr;
    logic [FW-1:0]   db;
    logic [63:0]     alt_out;
  } ctx_t;

  function automatic logic [RW-1:0] sat24(input logic signed [SATW-1:0] v);
    logic [RW-1:0] r;
    if (v > SAT_MAX) r = SAT_MAX[RW-1:0];
    else if (v < SAT_MIN) r = SAT_MIN[RW-1:0];
    else r = v[RW-1:0];
    return r;
  endfunction

endpackage

// File: src/sbsc_if.sv
// ----------------------------------------------------------------------------
// sbsc channel interfaces
// Sprite input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface sbsc_in_if #(parameter int COORD_BITS = 16);
  import sbsc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] sprite_x;
  logic signed [COORD_BITS-1:0] sprite_y;
  logic [SZW-1:0]               size_percent;
  logic [2:0]                   flags;
  logic [63:0]                  frame_box;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [63:0]                  alt_box;
  modport source (output valid, sprite_x, sprite_y, size_percent, flags, frame_box,
                  center_x, center_y, alt_box, input ready);
  modport sink (input valid, sprite_x, sprite_y, size_percent, flags, frame_box,
                center_x, center_y, alt_box, output ready);
endinterface

interface sbsc_out_if;
  import sbsc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 draw;
  logic signed [RW-1:0] scaled_left;
  logic signed [RW-1:0] scaled_top;
  logic signed [RW-1:0] scaled_right;
  logic signed [RW-1:0] scaled_bottom;
  logic signed [RW-1:0] real_left;
  logic signed [RW-1:0] real_top;
  logic signed [RW-1:0] real_right;
  logic signed [RW-1:0] real_bottom;
  logic [63:0]          alt_clamped;
  logic [SZW-1:0]       size_fixed;
  modport source (output valid, draw, scaled_left, scaled_top, scaled_right, scaled_bottom,
                  real_left, real_top, real_right, real_bottom, alt_clamped, size_fixed,
                  input ready);
  modport sink (input valid, draw, scaled_left, scaled_top, scaled_right, scaled_bottom,
                real_left, real_top, real_right, real_bottom, alt_clamped, size_fixed,
                output ready);
endinterface

interface sbsc_cfg_if;
  import sbsc_pkg::*;
  logic            valid;
  logic            ready;
  logic [IDXW-1:0] index;
  logic [PW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/sprite_box_scale_clip_unit.sv
// ----------------------------------------------------------------------------
// sprite_box_scale_clip_unit
// Scales a sprite's frame box, applies the alternate sub-box, clips to the
// play area and derives the matching source box.
// ----------------------------------------------------------------------------
// Usage:
//   sprite : one sprite item per valid/ready handshake.
//   result : one result item per sprite item, same order.
//   cfg    : play area writes (0 right, 1 left, 2 bottom, others dropped);
//            always ready; write only while the unit is empty (not enforced).
// Pipeline: stages A to G, the divider and the output stage.
//   DW = max(COORD_BITS,22)+9 (31 at COORD_BITS=16) is the divider depth:
//   a restoring divider per clipped edge produces one quotient bit per stage.
// Throughput: one item per cycle while result is taken.
// Reset: clears all stage valid bits and loads 620 / 20 / 400 into the play
//   area registers.
// Stall: each stage moves when it is empty or the stage behind it moves, so
//   bubbles are squeezed out while result is held; sprite.ready drops only
//   when every stage holds an item and result is not taken.
// ----------------------------------------------------------------------------
module sprite_box_scale_clip_unit #(
  parameter int COORD_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  sbsc_in_if.sink   sprite,
  sbsc_out_if.source result,
  sbsc_cfg_if.sink  cfg
);
  import sbsc_pkg::*;

  // coordinate working widths
  localparam int CW = (COORD_BITS > 22) ? COORD_BITS : 22;
  localparam int LW = CW + 3;   // signed box coordinate
  localparam int DW = CW + 9;   // dividend / quotient of offset*100/size
  localparam int NS = DW + 8;   // total stages
  localparam int ST_G = 6;      // clip stage, feeds the divider

  typedef struct packed {
    logic                 draw;
    logic signed [LW-1:0] sl;
    logic signed [LW-1:0] st;
    logic signed [LW-1:0] sr;
    logic signed [LW-1:0] sb;
    logic [FW-1:0]        rl;
    logic [FW-1:0]        rt;
    logic [FW-1:0]        rr;
    logic [FW-1:0]        rb;
    logic [63:0]          alt_out;
    logic [SZW-1:0]       sfix;
    logic [3:0][DW-1:0]   num;
    logic [3:0][SZW-1:0]  rem;
  } dv_t;

  // ---------------------------------------------------------------- config
  logic [PW-1:0] play_right, play_left, play_bottom;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      play_right  <= PLAY_RIGHT_RST;
      play_left   <= PLAY_LEFT_RST;
      play_bottom <= PLAY_BOTTOM_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PLAY_RIGHT:  play_right  <= cfg.data;
        REG_PLAY_LEFT:   play_left   <= cfg.data;
        REG_PLAY_BOTTOM: play_bottom <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  assign en[NS-1] = !v[NS-1] || result.ready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end
  assign sprite.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v[i] <= (i == 0) ? sprite.valid : v[i-1 < 0 ? 0 : i-1];
      end
    end
  end

  // ------------------------------------------------------ stage A: unpack
  function automatic logic [FW-1:0] clamp16(input logic [FW-1:0] raw, input logic [FW-1:0] hi);
    logic [FW-1:0] r;
    if (raw[FW-1]) r = '0;
    else if (raw > hi) r = hi;
    else r = raw;
    return r;
  endfunction

  function automatic logic [FW-1:0] pack16(input logic [FW-1:0] c);
    return c[FW-1] ? 16'h7fff : c;
  endfunction

  logic [FW-1:0]  fl, ft, fr, fbm, cal, cat, car, cab;
  logic [SZW-1:0] szm;
  logic           alt_on;
  ctx_t           a_ctx_next;

  always_comb begin
    fl  = sprite.frame_box[15:0];
    ft  = sprite.frame_box[31:16];
    fr  = sprite.frame_box[47:32];
    fbm = sprite.frame_box[63:48];
    cal = clamp16(sprite.alt_box[15:0], fr);
    cat = clamp16(sprite.alt_box[31:16], fbm);
    car = clamp16(sprite.alt_box[47:32], fr);
    cab = clamp16(sprite.alt_box[63:48], fbm);
    alt_on = (sprite.alt_box[15:0] != '0) || (sprite.alt_box[31:16] != '0) ||
             (sprite.alt_box[47:32] != '0);
    szm = (sprite.size_percent >= SIZE_UNIT) ? sprite.size_percent - SIZE_UNIT
                                             : SIZE_UNIT - sprite.size_percent;

    a_ctx_next.frame = sprite.flags[FLAG_FRAME];
    a_ctx_next.skip  = sprite.flags[FLAG_SKIP];
    a_ctx_next.pl    = sprite.flags[FLAG_NOCLIP] ? '0 : play_left;
    a_ctx_next.pr    = sprite.flags[FLAG_NOCLIP] ? SCREEN_W : play_right;
    a_ctx_next.pb    = sprite.flags[FLAG_NOCLIP] ? SCREEN_H : play_bottom;
    a_ctx_next.sfix  = (sprite.size_percent == '0) ? SIZE_UNIT : sprite.size_percent;
    a_ctx_next.rl    = alt_on ? cal : fl;
    a_ctx_next.rt    = alt_on ? cat : ft;
    a_ctx_next.rr    = alt_on ? car : fr;
    a_ctx_next.rb    = alt_on ? cab : fbm;
    a_ctx_next.dl    = alt_on ? cal : '0;
    a_ctx_next.dt    = alt_on ? cat : '0;
    a_ctx_next.dr    = alt_on ? fr - car : '0;
    a_ctx_next.db    = alt_on ? fbm - cab : '0;
    a_ctx_next.alt_out = (alt_on && sprite.flags[FLAG_FRAME]) ?
        {pack16(cab), pack16(car), pack16(cat), pack16(cal)} : sprite.alt_box;
  end

  ctx_t                 a_ctx;
  logic signed [LW-1:0] a_basel, a_baset;
  logic [27:0]          a_nc, a_ncy, a_nr, a_nb;
  logic                 a_neg;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_ctx   <= a_ctx_next;
      a_basel <= LW'(sprite.sprite_x) - LW'(sprite.center_x);
      a_baset <= LW'(sprite.sprite_y) - LW'(sprite.center_y);
      a_nc    <= 28'(fr) * 28'(szm);
      a_ncy   <= 28'(fbm) * 28'(szm);
      a_neg   <= sprite.size_percent < SIZE_UNIT;
      a_nr    <= 28'(fr) * 28'(sprite.size_percent);
      a_nb    <= 28'(fbm) * 28'(sprite.size_percent);
    end
  end

  // ------------------------------------------- stage B: reciprocal multiply
  logic [52:0] pc, pcy;
  logic [53:0] pr_, pb_;
  assign pc  = 53'(a_nc) * 53'(M200);
  assign pcy = 53'(a_ncy) * 53'(M200);
  assign pr_ = 54'(a_nr) * 54'(M100);
  assign pb_ = 54'(a_nb) * 54'(M100);

  ctx_t                 b_ctx;
  logic signed [LW-1:0] b_basel, b_baset;
  logic [27:0]          b_nc, b_ncy, b_nr, b_nb;
  logic                 b_neg;
  logic [20:0]          b_q0c, b_q0cy;
  logic [21:0]          b_q0r, b_q0b;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_ctx   <= a_ctx;
      b_basel <= a_basel;
      b_baset <= a_baset;
      b_nc    <= a_nc;
      b_ncy   <= a_ncy;
      b_nr    <= a_nr;
      b_nb    <= a_nb;
      b_neg   <= a_neg;
      b_q0c   <= pc[52:32];
      b_q0cy  <= pcy[52:32];
      b_q0r   <= pr_[53:32];
      b_q0b   <= pb_[53:32];
    end
  end

  // ------------------------------------------ stage C: quotient correction
  logic [27:0] rc, rcy, rr_, rb_;
  logic [20:0] qc, qcy;
  assign rc  = b_nc - 28'(b_q0c) * D200;
  assign rcy = b_ncy - 28'(b_q0cy) * D200;
  assign rr_ = b_nr - 28'(b_q0r) * D100;
  assign rb_ = b_nb - 28'(b_q0b) * D100;
  assign qc  = (rc >= D200) ? b_q0c + 21'd1 : b_q0c;
  assign qcy = (rcy >= D200) ? b_q0cy + 21'd1 : b_q0cy;

  ctx_t                 c_ctx;
  logic signed [LW-1:0] c_basel, c_baset;
  logic signed [22:0]   c_xc, c_yc;
  logic [21:0]          c_qr, c_qb;
  logic                 c_nzr, c_nzb;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c_ctx   <= b_ctx;
      c_basel <= b_basel;
      c_baset <= b_baset;
      c_xc    <= b_neg ? -$signed({2'b0, qc}) : $signed({2'b0, qc});
      c_yc    <= b_neg ? -$signed({2'b0, qcy}) : $signed({2'b0, qcy});
      c_qr    <= (rr_ >= D100) ? b_q0r + 22'd1 : b_q0r;
      c_qb    <= (rb_ >= D100) ? b_q0b + 22'd1 : b_q0b;
      c_nzr   <= (rr_ != '0) && (rr_ != D100);
      c_nzb   <= (rb_ != '0) && (rb_ != D100);
    end
  end

  // ------------------------------------------- stage D: legacy offset rule
  ctx_t                 d_ctx;
  logic signed [LW-1:0] d_sl, d_st;
  logic [21:0]          d_qr, d_qb;
  logic                 d_nzr, d_nzb;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_ctx <= c_ctx;
      d_sl  <= c_basel - LW'(c_xc);
      d_st  <= c_baset - LW'(c_yc);
      d_qr  <= c_qr;
      d_qb  <= c_qb;
      d_nzr <= c_nzr;
      d_nzb <= c_nzb;
    end
  end

  // ------------------- stage E: alt offset on left/top, sums for right/bottom
  ctx_t                 e_ctx;
  logic signed [LW-1:0] e_sl, e_st, e_tr, e_tb;
  logic                 e_nzr, e_nzb;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      e_ctx <= d_ctx;
      e_sl  <= d_sl + LW'($signed({1'b0, d_ctx.dl}));
      e_st  <= d_st + LW'($signed({1'b0, d_ctx.dt}));
      e_tr  <= d_sl + LW'($signed({1'b0, d_qr}));
      e_tb  <= d_st + LW'($signed({1'b0, d_qb}));
      e_nzr <= d_nzr;
      e_nzb <= d_nzb;
    end
  end

  // ------------------- stage F: round toward zero, alt shrink on right/bottom
  ctx_t                 f_ctx;
  logic signed [LW-1:0] f_sl, f_st, f_sr, f_sb;
  logic                 fixr, fixb;
  assign fixr = e_tr[LW-1] && e_nzr;
  assign fixb = e_tb[LW-1] && e_nzb;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      f_ctx <= e_ctx;
      f_sl  <= e_sl;
      f_st  <= e_st;
      f_sr  <= e_tr + LW'(fixr) - LW'($signed({1'b0, e_ctx.dr}));
      f_sb  <= e_tb + LW'(fixb) - LW'($signed({1'b0, e_ctx.db}));
    end
  end

  // -------------------------------------- stage G: clip decisions, dividends
  logic signed [LW-1:0] plx, prx, pbx, sl2, st2;
  logic signed [LW-1:0] offl, offt, offr, offb;
  logic                 clip_en, cl, ct, cr, cb, d1, d2, d3, d4;
  dv_t                  g_next;

  always_comb begin
    plx = $signed(LW'(f_ctx.pl));
    prx = $signed(LW'(f_ctx.pr));
    pbx = $signed(LW'(f_ctx.pb));
    clip_en = f_ctx.frame && !f_ctx.skip;
    cl = clip_en && (f_sl < plx);
    ct = clip_en && f_st[LW-1];
    cr = clip_en && (f_sr > prx);
    cb = clip_en && (f_sb > pbx);
    sl2 = cl ? plx : f_sl;
    st2 = ct ? '0 : f_st;
    offl = plx - f_sl;
    offt = -f_st;
    offr = f_sr - prx;
    offb = f_sb - pbx;
    // edges are checked in order; a vanished sprite stops the chain
    d1 = f_ctx.frame && !(cl && (f_sr <= plx));
    d2 = d1 && !(ct && (f_sb <= $signed(LW'(0))));
    d3 = d2 && !(cr && (sl2 >= prx));
    d4 = d3 && !(cb && (st2 >= pbx));

    g_next.draw    = d4;
    g_next.sl      = sl2;
    g_next.st      = st2;
    g_next.sr      = cr ? prx : f_sr;
    g_next.sb      = cb ? pbx : f_sb;
    g_next.rl      = f_ctx.rl;
    g_next.rt      = f_ctx.rt;
    g_next.rr      = f_ctx.rr;
    g_next.rb      = f_ctx.rb;
    g_next.alt_out = f_ctx.alt_out;
    g_next.sfix    = f_ctx.sfix;
    g_next.num[0]  = cl ? DW'(offl) * DW'(100) : '0;
    g_next.num[1]  = ct ? DW'(offt) * DW'(100) : '0;
    g_next.num[2]  = cr ? DW'(offr) * DW'(100) : '0;
    g_next.num[3]  = cb ? DW'(offb) * DW'(100) : '0;
    g_next.rem     = '0;
  end

  dv_t dv [DW+1];

  always_ff @(posedge clk) begin
    if (en[ST_G]) dv[0] <= g_next;
  end

  // ------------------------- divider: offset*100/size, one bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    dv_t nxt;
    always_comb begin
      logic [SZW:0] trial;
      logic         ge;
      nxt = dv[k];
      for (int j = 0; j < 4; j++) begin
        trial = {dv[k].rem[j], dv[k].num[j][DW-1]};
        ge = trial >= {1'b0, dv[k].sfix};
        nxt.rem[j] = ge ? SZW'(trial - {1'b0, dv[k].sfix}) : trial[SZW-1:0];
        nxt.num[j] = {dv[k].num[j][DW-2:0], ge};
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_G+1+k]) dv[k+1] <= nxt;
    end
  end

  // ------------------------------------- output stage: apply and saturate
  dv_t                    fin;
  logic signed [SATW-1:0] rl40, rt40, rr40, rb40;
  assign fin  = dv[DW];
  assign rl40 = $signed(SATW'(fin.rl)) + $signed(SATW'(fin.num[0]));
  assign rt40 = $signed(SATW'(fin.rt)) + $signed(SATW'(fin.num[1]));
  assign rr40 = $signed(SATW'(fin.rr)) - $signed(SATW'(fin.num[2]));
  assign rb40 = $signed(SATW'(fin.rb)) - $signed(SATW'(fin.num[3]));

  logic           o_draw;
  logic [RW-1:0]  o_sl, o_st, o_sr, o_sb, o_rl, o_rt, o_rr, o_rb;
  logic [63:0]    o_alt;
  logic [SZW-1:0] o_size;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      o_draw <= fin.draw;
      o_sl   <= fin.draw ? sat24(SATW'(fin.sl)) : '0;
      o_st   <= fin.draw ? sat24(SATW'(fin.st)) : '0;
      o_sr   <= fin.draw ? sat24(SATW'(fin.sr)) : '0;
      o_sb   <= fin.draw ? sat24(SATW'(fin.sb)) : '0;
      o_rl   <= fin.draw ? sat24(rl40) : '0;
      o_rt   <= fin.draw ? sat24(rt40) : '0;
      o_rr   <= fin.draw ? sat24(rr40) : '0;
      o_rb   <= fin.draw ? sat24(rb40) : '0;
      o_alt  <= fin.alt_out;
      o_size <= fin.sfix;
    end
  end

  assign result.valid         = v[NS-1];
  assign result.draw          = o_draw;
  assign result.scaled_left   = o_sl;
  assign result.scaled_top    = o_st;
  assign result.scaled_right  = o_sr;
  assign result.scaled_bottom = o_sb;
  assign result.real_left     = o_rl;
  assign result.real_top      = o_rt;
  assign result.real_right    = o_rr;
  assign result.real_bottom   = o_rb;
  assign result.alt_clamped   = o_alt;
  assign result.size_fixed    = o_size;

  // ------------------------------------------------------------ assertions
`include "sprite_box_scale_clip_unit_assert.svh"

  `SBSC_IMPLIES(a_nodraw_zero, result.valid && !result.draw, (result.scaled_left == '0) && (result.scaled_right == '0) && (result.real_left == '0) && (result.real_bottom == '0), "box not zero on a no-draw item")
  `SBSC_IMPLIES(a_size_nonzero, result.valid, result.size_fixed != '0, "size_fixed is zero")
  `SBSC_IMPLIES(a_full_stall, (&v) && !result.ready, !sprite.ready, "input taken into a full stalled pipe")

endmodule
